>>> rtl/core/vrp_pkg.sv
// Shared types and constants for the video RAM register port.
// Holds the command codes, sequencer states, register indexes and the power-up table.
// No dependencies.
`default_nettype none

package vrp_pkg;

	// Host command codes.
	typedef enum logic [1:0] {
		FN_ADDR   = 2'd0,
		FN_STATUS = 2'd1,
		FN_WDATA  = 2'd2,
		FN_RDATA  = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REG_RD,
		ST_VRD,
		ST_FILL,
		ST_CP_RD,
		ST_CP_WR
	} state_t;

	// Register indexes with a special meaning.
	localparam logic [5:0] REG_UPD_HI   = 6'd18;
	localparam logic [5:0] REG_UPD_LO   = 6'd19;
	localparam logic [5:0] REG_COPY_CTL = 6'd24;
	localparam logic [5:0] REG_BLOCK    = 6'd30;
	localparam logic [5:0] REG_DATA     = 6'd31;
	localparam logic [5:0] REG_SRC_HI   = 6'd32;
	localparam logic [5:0] REG_SRC_LO   = 6'd33;

	localparam logic [7:0] STATUS_READY = 8'h80;
	localparam logic [7:0] STATUS_BUSY  = 8'h00;
	localparam logic [7:0] BYTE_NONE    = 8'hFF;

	localparam int TABLE_LEN = 38;

	// Register contents after power-up.
	localparam logic [7:0] POWER_UP [TABLE_LEN] = '{
		8'd126, 8'd80,  8'd102, 8'd73,  8'd32,  8'd224, 8'd25,  8'd29,
		8'd252, 8'd231, 8'd160, 8'd231, 8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd15,  8'd228, 8'd8,   8'd0,   8'd120, 8'd232,
		8'd32,  8'd71,  8'd240, 8'd0,   8'd63,  8'd21,  8'd79,  8'd0,
		8'd0,   8'd0,   8'd125, 8'd100, 8'd245, 8'd63
	};

	// Power-up value of a register; registers past the table start at zero.
	function automatic logic [7:0] reg_init(input logic [5:0] idx);
		if (idx < 6'(TABLE_LEN)) begin
			return POWER_UP[idx];
		end
		return 8'h00;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/vrp_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Used for both the register file and the video memory; no dependencies.
`default_nettype none

module vrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read share the address; a read during a write returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

>>> rtl/core/video_ram_register_port.sv
// Top level of the video RAM register port: command sequencer, pointer registers
// and the two memories. Depends on vrp_pkg and vrp_ram.
`default_nettype none

// A command is taken at a rising edge with start high and busy low; its single
// result appears on rdata with done high for one cycle and cannot be held off.
// Status reads and data writes, save to register 30, answer from idle; address writes
// go through a register file read, data reads through register 31 through a video
// memory read. A write to register 30 fills or copies count bytes (zero means 256),
// a copied byte being a read then a write on the one video memory port. After reset
// the block runs a clearing pass over every video memory entry, zeroing the video
// memory and loading the register file, with busy high. A video memory smaller
// than 64K is addressed by pointer modulo depth, for pointers below 16 * depth.

module video_ram_register_port
	import vrp_pkg::*;
#(
	parameter int VRAM_DEPTH = 65536,
	parameter int NUM_REGS   = 38
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] func,
	input  wire logic [7:0] wdata,
	output logic            done,
	output logic [7:0]      rdata
);

	localparam int VAW = $clog2(VRAM_DEPTH);
	localparam int RAW = $clog2(NUM_REGS);

	// Pointer to video memory entry: reduce modulo depth by four conditional subtracts (exact below 16 * depth).
	function automatic logic [VAW-1:0] vidx(input logic [15:0] p);
		logic [19:0] r;
		r = {4'b0, p};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (20'(VRAM_DEPTH) << k)) begin
				r = r - (20'(VRAM_DEPTH) << k);
			end
		end
		return r[VAW-1:0];
	endfunction

	state_t         state_q, state_nx;
	logic [VAW-1:0] clr_q;
	logic [5:0]     sel_q;
	logic [7:0]     latch_q;
	logic           ready_q;
	logic [15:0]    ptr_upd_q;
	logic [15:0]    ptr_src_q;
	logic           copy_q;
	logic [7:0]     fill_q;
	logic [8:0]     cnt_q;
	logic           done_q;
	logic [7:0]     rdata_q;

	logic           acc;
	func_t          fn;
	logic           sel_ok;
	logic           last;
	logic [7:0]     reg_val;

	logic           vram_we;
	logic [VAW-1:0] vram_addr;
	logic [7:0]     vram_wd;
	logic [7:0]     vram_rd;
	logic           reg_we;
	logic [RAW-1:0] reg_addr;
	logic [7:0]     reg_wd;
	logic [7:0]     reg_rd;

	assign busy   = (state_q != ST_IDLE);
	assign acc    = start && !busy;
	assign fn     = func_t'(func);
	assign sel_ok = ({1'b0, sel_q} < 7'(NUM_REGS));
	assign last   = (cnt_q == 9'd1);
	assign done   = done_q;
	assign rdata  = rdata_q;

	// Memories.
	vrp_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.addr  (vram_addr),
		.wdata (vram_wd),
		.rdata (vram_rd)
	);

	vrp_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
		.clk   (clk),
		.we    (reg_we),
		.addr  (reg_addr),
		.wdata (reg_wd),
		.rdata (reg_rd)
	);

	// Latched register byte: pointers live in flops, an index past the file reads as FFh, the rest comes from the file.
	always_comb begin
		priority if (!sel_ok) begin
			reg_val = BYTE_NONE;
		end else if (sel_q == REG_UPD_HI) begin
			reg_val = ptr_upd_q[15:8];
		end else if (sel_q == REG_UPD_LO) begin
			reg_val = ptr_upd_q[7:0];
		end else if (sel_q == REG_SRC_HI) begin
			reg_val = ptr_src_q[15:8];
		end else if (sel_q == REG_SRC_LO) begin
			reg_val = ptr_src_q[7:0];
		end else begin
			reg_val = reg_rd;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == VAW'(VRAM_DEPTH - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (fn)
						FN_ADDR: state_nx = ST_REG_RD;
						FN_STATUS: state_nx = ST_IDLE;
						FN_WDATA: begin
							if (sel_ok && sel_q == REG_BLOCK) begin
								state_nx = copy_q ? ST_CP_RD : ST_FILL;
							end
						end
						FN_RDATA: begin
							if (ready_q && sel_q == REG_DATA) begin
								state_nx = ST_VRD;
							end
						end
					endcase
				end
			end
			ST_REG_RD: state_nx = ST_IDLE;
			ST_VRD:    state_nx = ST_IDLE;
			ST_FILL: begin
				if (last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_CP_RD: state_nx = ST_CP_WR;
			ST_CP_WR: state_nx = last ? ST_IDLE : ST_CP_RD;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		vram_we   = 1'b0;
		vram_addr = vidx(ptr_upd_q);
		vram_wd   = 8'h00;
		reg_we    = 1'b0;
		reg_addr  = sel_q[RAW-1:0];
		reg_wd    = wdata;
		unique case (state_q)
			ST_CLEAR: begin
				vram_we   = 1'b1;
				vram_addr = clr_q;
				reg_we    = ({1'b0, clr_q} < (VAW+1)'(NUM_REGS));
				reg_addr  = clr_q[RAW-1:0];
				reg_wd    = reg_init(clr_q[5:0]);
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (fn)
						FN_ADDR: reg_addr = wdata[RAW-1:0];
						FN_STATUS: ;
						FN_WDATA: begin
							reg_we = sel_ok;
							if (sel_ok && sel_q == REG_DATA) begin
								vram_we = 1'b1;
								vram_wd = wdata;
							end
						end
						FN_RDATA: ;
					endcase
				end
			end
			ST_FILL: begin
				vram_we = 1'b1;
				vram_wd = fill_q;
			end
			ST_CP_RD: vram_addr = vidx(ptr_src_q);
			ST_CP_WR: begin
				vram_we = 1'b1;
				vram_wd = vram_rd;
			end
			default: ;
		endcase
	end

	// Register updates and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			sel_q     <= '0;
			latch_q   <= 8'h00;
			ready_q   <= 1'b0;
			ptr_upd_q <= {POWER_UP[REG_UPD_HI], POWER_UP[REG_UPD_LO]};
			ptr_src_q <= {POWER_UP[REG_SRC_HI], POWER_UP[REG_SRC_LO]};
			copy_q    <= POWER_UP[REG_COPY_CTL][7];
			fill_q    <= POWER_UP[REG_DATA];
			cnt_q     <= '0;
			done_q    <= 1'b0;
			rdata_q   <= 8'h00;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + VAW'(1);
				ST_IDLE: begin
					if (acc) begin
						unique case (fn)
							FN_ADDR: begin
								sel_q   <= wdata[5:0];
								ready_q <= 1'b0;
								rdata_q <= 8'h00;
							end
							FN_STATUS: begin
								done_q  <= 1'b1;
								rdata_q <= ready_q ? STATUS_READY : STATUS_BUSY;
								ready_q <= 1'b1;
							end
							FN_WDATA: begin
								ready_q <= 1'b1;
								rdata_q <= 8'h00;
								done_q  <= !(sel_ok && sel_q == REG_BLOCK);
								if (sel_ok) begin
									if (sel_q == REG_DATA) begin
										fill_q    <= wdata;
										ptr_upd_q <= ptr_upd_q + 16'd1;
									end
									if (sel_q == REG_BLOCK) begin
										cnt_q <= {(wdata == 8'h00), wdata};
									end
									if (sel_q == REG_UPD_HI) begin
										ptr_upd_q[15:8] <= wdata;
									end
									if (sel_q == REG_UPD_LO) begin
										ptr_upd_q[7:0] <= wdata;
									end
									if (sel_q == REG_SRC_HI) begin
										ptr_src_q[15:8] <= wdata;
									end
									if (sel_q == REG_SRC_LO) begin
										ptr_src_q[7:0] <= wdata;
									end
									if (sel_q == REG_COPY_CTL) begin
										copy_q <= wdata[7];
									end
								end
							end
							FN_RDATA: begin
								priority if (!ready_q) begin
									ready_q <= 1'b1;
									done_q  <= 1'b1;
									rdata_q <= BYTE_NONE;
								end else if (sel_q == REG_DATA) begin
									ptr_upd_q <= ptr_upd_q + 16'd1;
								end else begin
									done_q  <= 1'b1;
									rdata_q <= latch_q;
								end
							end
						endcase
					end
				end
				ST_REG_RD: begin
					latch_q <= reg_val;
					done_q  <= 1'b1;
				end
				ST_VRD: begin
					latch_q <= vram_rd;
					rdata_q <= vram_rd;
					done_q  <= 1'b1;
				end
				ST_FILL: begin
					ptr_upd_q <= ptr_upd_q + 16'd1;
					cnt_q     <= cnt_q - 9'd1;
					done_q    <= last;
				end
				ST_CP_RD: ptr_src_q <= ptr_src_q + 16'd1;
				ST_CP_WR: begin
					ptr_upd_q <= ptr_upd_q + 16'd1;
					cnt_q     <= cnt_q - 9'd1;
					done_q    <= last;
				end
				default: ;
			endcase
		end
	end

	// Results only ever leave when the sequencer has come back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result beat while the sequencer is still working");

	// No result during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done_q)
		else $error("result beat during the clearing pass");

	// A status read answers in the following cycle.
	a_status_next: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && fn == FN_STATUS) |=> done_q)
		else $error("status read did not answer in the next cycle");

	// The byte counter never runs out in the middle of a block operation.
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_CP_RD || state_q == ST_CP_WR)
		|-> (cnt_q != 9'd0))
		else $error("block operation running with an empty byte count");

	// Every copy read is followed by its write.
	a_copy_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CP_RD) |=> (state_q == ST_CP_WR))
		else $error("copy read not followed by its write");

endmodule

`default_nettype wire
